// ----- hdl/teas_pkg.sv -----
// Shared constants for the earliest-arrival scan block: operation codes, payload
// field widths, default sizes and the epoch tag width. No dependencies.
package teas_pkg;

    // Operation codes carried on the input tuser
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_EDGE  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Fixed field widths of the stream payload
    localparam int OP_W     = 2;
    localparam int VERTEX_W = 16;
    localparam int TIME_W   = 31;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 40;

    // Default sizes
    localparam int DEF_VERTICES  = 65536;
    localparam int DEF_TIME_BITS = 31;

    // Epoch tag kept beside each label; tag zero never matches
    localparam int EPOCH_BITS = 8;

endpackage

// ----- hdl/teas_ram.sv -----
// Label memory of the earliest-arrival scan: one write port and two
// registered read ports. Depends on teas_pkg for its default sizes.
module teas_ram #(
    parameter int DEPTH = teas_pkg::DEF_VERTICES,
    parameter int WIDTH = teas_pkg::DEF_TIME_BITS + teas_pkg::EPOCH_BITS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr_a,
    input  logic [AW-1:0]    i_rd_addr_b,
    output logic [WIDTH-1:0] o_rd_data_a,
    output logic [WIDTH-1:0] o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read two entries into registered outputs
    always_ff @(posedge i_clk) begin
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

// ----- hdl/temporal_earliest_arrival_scan.sv -----
// Top level of the earliest-arrival scan over time-ordered temporal edges.
// Depends on teas_pkg and teas_ram (label memory with epoch tags).
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser: operation; tdata: vertices, times
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: label_time, reached, improved
//
// Each request has its from and to entries read from the label memory as it is
// accepted in the idle state, then is updated, written back and loaded into the
// output register in the execute state. After reset the block sweeps all
// VERTICES entries before taking a request. The 255th start request after reset,
// and every 254th one after that, sweeps again before it completes, since
// the epoch tag that marks an entry reached runs out of values.
// A result waits in the output register; a request finishing while it is
// still held stalls in the execute state until the register is taken.
module temporal_earliest_arrival_scan #(
    parameter int VERTICES  = teas_pkg::DEF_VERTICES,
    parameter int TIME_BITS = teas_pkg::DEF_TIME_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] from_vertex, [31:16] to_vertex, [62:32] departure_time,
    // [93:63] arrival_time, [95:94] zero
    input  logic [teas_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] operation
    input  logic [teas_pkg::OP_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [30:0] label_time, [31] reached, [32] improved, [39:33] zero
    output logic [teas_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    import teas_pkg::*;

    localparam int AW    = $clog2(VERTICES);
    localparam int TW    = TIME_BITS;
    localparam int MW    = EPOCH_BITS + TW;
    localparam int CW    = VERTEX_W + AW + 1;
    localparam int PW    = VERTEX_W + AW;
    localparam int XW    = TW + TIME_W;

    localparam logic [AW-1:0]         LAST_ADDR = AW'(VERTICES - 1);
    localparam logic [CW-1:0]         VERT_LIM  = CW'(VERTICES);
    localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = {EPOCH_BITS{1'b1}};
    localparam logic [EPOCH_BITS-1:0] EPOCH_ONE = EPOCH_BITS'(1);
    localparam logic [TW-1:0]         TIME_INF  = {TW{1'b1}};

    // State codes
    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [AW-1:0]         r_clr_addr;
    logic                  r_boot;
    logic [EPOCH_BITS-1:0] r_epoch;

    // Held request
    logic [OP_W-1:0]       r_op;
    logic [VERTEX_W-1:0]   r_from;
    logic [VERTEX_W-1:0]   r_to;
    logic [TIME_W-1:0]     r_dep;
    logic [TIME_W-1:0]     r_arr;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                  in_fire;
    logic                  out_free;
    logic                  wrap;
    logic                  done;

    logic [VERTEX_W-1:0]   rd_from_v, rd_to_v;
    logic [PW-1:0]         pad_a, pad_b, pad_from, pad_to;
    logic [AW-1:0]         rd_addr_a, rd_addr_b, addr_from, addr_to;
    logic [MW-1:0]         rd_data_a, rd_data_b;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [MW-1:0]         wr_data;

    logic [EPOCH_BITS-1:0] tag_a, tag_b, epoch_inc;
    logic [TW-1:0]         lbl_a, lbl_b;
    logic [XW-1:0]         dep_ext, arr_ext;
    logic [TW-1:0]         dep_t, arr_t;
    logic                  in_from, in_to;
    logic                  valid_a, valid_b;
    logic                  take, improve;

    logic                  res_wr;
    logic [MW-1:0]         res_wr_data;
    logic [AW-1:0]         res_wr_addr;
    logic [TW-1:0]         res_label;
    logic [XW-1:0]         res_label_ext;
    logic                  res_reached;
    logic                  res_improved;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign wrap          = (r_op == OP_START) && (r_epoch == EPOCH_MAX);
    assign done          = (r_state == S_EXEC) && out_free && !wrap;

    // Read addresses: incoming request while idle, held request otherwise
    assign rd_from_v = (r_state == S_IDLE) ? s_axis_tdata[15:0]  : r_from;
    assign rd_to_v   = (r_state == S_IDLE) ? s_axis_tdata[31:16] : r_to;
    assign pad_a     = {{AW{1'b0}}, rd_from_v};
    assign pad_b     = {{AW{1'b0}}, rd_to_v};
    assign rd_addr_a = pad_a[AW-1:0];
    assign rd_addr_b = pad_b[AW-1:0];
    assign pad_from  = {{AW{1'b0}}, r_from};
    assign pad_to    = {{AW{1'b0}}, r_to};
    assign addr_from = pad_from[AW-1:0];
    assign addr_to   = pad_to[AW-1:0];

    teas_ram #(
        .DEPTH (VERTICES),
        .WIDTH (MW),
        .AW    (AW)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b)
    );

    // Split entries and bring times to the label width
    assign tag_a     = rd_data_a[MW-1:TW];
    assign lbl_a     = rd_data_a[TW-1:0];
    assign tag_b     = rd_data_b[MW-1:TW];
    assign lbl_b     = rd_data_b[TW-1:0];
    assign dep_ext   = {{TW{1'b0}}, r_dep};
    assign arr_ext   = {{TW{1'b0}}, r_arr};
    assign dep_t     = dep_ext[TW-1:0];
    assign arr_t     = arr_ext[TW-1:0];
    assign epoch_inc = r_epoch + 1'b1;

    assign in_from = (CW'(r_from) < VERT_LIM);
    assign in_to   = (CW'(r_to) < VERT_LIM);
    assign valid_a = in_from && (tag_a == r_epoch);
    assign valid_b = in_to && (tag_b == r_epoch);
    assign take    = in_from && in_to && valid_a && (dep_t >= lbl_a);
    assign improve = take && (!valid_b || (arr_t < lbl_b));

    // Update and result of the held request
    always_comb begin
        res_wr       = 1'b0;
        res_wr_addr  = addr_to;
        res_wr_data  = {r_epoch, arr_t};
        res_label    = '0;
        res_reached  = 1'b0;
        res_improved = 1'b0;
        case (r_op)
            OP_START: begin
                res_wr      = in_from;
                res_wr_addr = addr_from;
                res_wr_data = {epoch_inc, dep_t};
                res_label   = in_from ? dep_t : TIME_INF;
                res_reached = in_from;
            end
            OP_EDGE: begin
                res_wr       = improve;
                res_label    = improve ? arr_t : (valid_b ? lbl_b : TIME_INF);
                res_reached  = improve || valid_b;
                res_improved = improve;
            end
            OP_READ: begin
                res_label   = valid_a ? lbl_a : TIME_INF;
                res_reached = valid_a;
            end
            default: begin
                res_label   = '0;
            end
        endcase
    end

    assign res_label_ext = {{TIME_W{1'b0}}, res_label};

    // Memory write: sweep entry or write back of a finished request
    always_comb begin
        if (r_state == S_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = done && res_wr;
            wr_addr = res_wr_addr;
            wr_data = res_wr_data;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = r_boot ? S_IDLE : S_EXEC;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (wrap) begin
                    n_state = S_CLEAR;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_boot     <= 1'b1;
            r_epoch    <= EPOCH_ONE;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    r_epoch <= EPOCH_ONE;
                end
            end
            if ((r_state == S_EXEC) && wrap) begin
                r_clr_addr <= '0;
                r_boot     <= 1'b0;
            end
            if (done && (r_op == OP_START)) begin
                r_epoch <= epoch_inc;
            end
        end
    end

    // Hold the accepted request
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op   <= s_axis_tuser;
            r_from <= s_axis_tdata[15:0];
            r_to   <= s_axis_tdata[31:16];
            r_dep  <= s_axis_tdata[62:32];
            r_arr  <= s_axis_tdata[93:63];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_data <= {7'd0, res_improved, res_reached,
                           res_label_ext[TIME_W-1:0]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Checks
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_EXEC))
        else $error("accepted request did not move to execute");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !wr_en)
        else $error("memory written while idle");

    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |-> (r_epoch != '0))
        else $error("epoch tag zero in use");

    a_improved_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[32]) |-> m_axis_tdata[31])
        else $error("improved result without reached flag");

endmodule

// ----- verif/teas_scoreboard.sv -----
`timescale 1ns / 1ps
// Scoreboard for the earliest-arrival scan block: watches the request and result
// streams, keeps its own label store, predicts every result and compares it.
// Depends on teas_pkg for operation codes and payload widths.
module teas_scoreboard (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_ready,
    // [15:0] from_vertex, [31:16] to_vertex, [62:32] departure_time,
    // [93:63] arrival_time, [95:94] zero
    input  logic [teas_pkg::IN_DATA_W-1:0]  i_req_data,
    // [1:0] operation
    input  logic [teas_pkg::OP_W-1:0]       i_req_user,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    // [30:0] label_time, [31] reached, [32] improved, [39:33] zero
    input  logic [teas_pkg::OUT_DATA_W-1:0] i_res_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import teas_pkg::*;

    typedef struct packed {
        logic [TIME_W-1:0] label_time;
        logic              reached;
        logic              improved;
    } t_scan_result;

    localparam logic [TIME_W-1:0] UNREACHED_LABEL = '1;

    // Label store; a vertex counts as reached only when its tag equals the
    // number of the current query, so a start clears every flag at once
    logic [TIME_W-1:0] label_store [0:DEF_VERTICES-1];
    int unsigned       label_query [0:DEF_VERTICES-1];
    int unsigned       query_id = 0;

    t_scan_result expected_results[$];
    int           fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic bit vertex_reached(input logic [VERTEX_W-1:0] v);
        return query_id != 0 && label_query[v] == query_id;
    endfunction

    // Apply one request to the label store and return the result it causes
    function automatic t_scan_result relax_labels(input logic [OP_W-1:0] op,
                                                  input logic [VERTEX_W-1:0] from_v,
                                                  input logic [VERTEX_W-1:0] to_v,
                                                  input logic [TIME_W-1:0] dep_t,
                                                  input logic [TIME_W-1:0] arr_t);
        t_scan_result res;
        logic [VERTEX_W-1:0] addr;
        res  = '{label_time: UNREACHED_LABEL, reached: 1'b0, improved: 1'b0};
        addr = from_v;
        case (op)
            OP_START: begin
                query_id++;
                label_store[from_v] = dep_t;
                label_query[from_v] = query_id;
            end
            OP_EDGE: begin
                addr = to_v;
                if (vertex_reached(from_v) && dep_t >= label_store[from_v] &&
                    (!vertex_reached(to_v) || arr_t < label_store[to_v])) begin
                    label_store[to_v] = arr_t;
                    label_query[to_v] = query_id;
                    res.improved      = 1'b1;
                end
            end
            OP_READ: ;
            default: return '0;
        endcase
        if (vertex_reached(addr)) begin
            res.label_time = label_store[addr];
            res.reached    = 1'b1;
        end
        return res;
    endfunction

    // Compare results first: a request taken at this edge cannot answer yet
    always @(posedge i_clk) begin
        t_scan_result want;
        if (i_rst_n) begin
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no request waiting: data %h", i_res_data);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_res_data[TIME_W-1:0] !== want.label_time) begin
                        $error("label_time mismatch: expected %0d, got %0d",
                               want.label_time, i_res_data[TIME_W-1:0]);
                        fail_count++;
                    end
                    if (i_res_data[TIME_W] !== want.reached) begin
                        $error("reached mismatch: expected %0d, got %0d",
                               want.reached, i_res_data[TIME_W]);
                        fail_count++;
                    end
                    if (i_res_data[TIME_W+1] !== want.improved) begin
                        $error("improved mismatch: expected %0d, got %0d",
                               want.improved, i_res_data[TIME_W+1]);
                        fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                expected_results.insert(expected_results.size(), relax_labels(
                    i_req_user,
                    i_req_data[VERTEX_W-1:0],
                    i_req_data[2*VERTEX_W-1:VERTEX_W],
                    i_req_data[2*VERTEX_W+TIME_W-1:2*VERTEX_W],
                    i_req_data[2*VERTEX_W+2*TIME_W-1:2*VERTEX_W+TIME_W]));
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- verif/temporal_earliest_arrival_scan_test.sv -----
`timescale 1ns / 1ps
// Testbench top for the earliest-arrival scan block: drives query, edge, read and unknown
// requests with bursty timing and random result backpressure, gives the verdict.
// Depends on teas_pkg, the block under test and teas_scoreboard.
module temporal_earliest_arrival_scan_test;
    import teas_pkg::*;

    localparam logic [OP_W-1:0]   OP_UNKNOWN     = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX       = 31'h7FFF_FFFE;
    localparam int                RANDOM_ITEMS   = 2000;
    localparam int                WRAP_STARTS    = 270;
    localparam int                WATCHDOG_LIMIT = 200000;
    localparam int                DRAIN_CYCLES   = 16;

    typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_STALLS} t_ready_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [15:0] from_vertex, [31:16] to_vertex, [62:32] departure_time,
    // [93:63] arrival_time, [95:94] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // [1:0] operation
    logic [OP_W-1:0]       s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [30:0] label_time, [31] reached, [32] improved, [39:33] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int burst_left  = 0;
    int start_count = 0;
    int scan_count  = 0;
    int read_count  = 0;
    int other_count = 0;

    t_ready_mode ready_mode      = READY_ALWAYS;
    int unsigned ready_mode_left = 0;
    int unsigned stall_left      = 0;

    temporal_earliest_arrival_scan uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    teas_scoreboard scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_user   (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #4 i_clk = ~i_clk;

    // Stop the run when nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result backpressure: switch between a few stall patterns every so often
    always @(negedge i_clk) begin
        if (ready_mode_left == 0) begin
            ready_mode      = t_ready_mode'($urandom_range(READY_ALWAYS, READY_STALLS));
            ready_mode_left = $urandom_range(50, 400);
        end else begin
            ready_mode_left--;
        end
        case (ready_mode)
            READY_ALWAYS: m_axis_tready <= 1'b1;
            READY_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
            READY_RARELY: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (stall_left != 0) begin
                    stall_left--;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 3) == 0)
                        stall_left = $urandom_range(4, 24);
                end
            end
        endcase
    end

    function automatic logic [VERTEX_W-1:0] any_vertex();
        logic [31:0] r;
        r = $urandom;
        return r[VERTEX_W-1:0];
    endfunction

    // Mostly a small neighborhood so labels meet, sometimes the corners or anywhere
    function automatic logic [VERTEX_W-1:0] pick_vertex();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return VERTEX_W'($urandom_range(0, 15));
        if (roll < 75)
            return '0;
        if (roll < 80)
            return '1;
        return any_vertex();
    endfunction

    function automatic logic [TIME_W-1:0] any_time();
        logic [31:0] r;
        r = $urandom_range(0, TIME_MAX);
        return r[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] pick_start_time();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return TIME_W'($urandom_range(0, 1000));
        if (roll < 85)
            return any_time();
        return TIME_MAX - TIME_W'($urandom_range(0, 200));
    endfunction

    // Advance a time, saturating at the largest legal value
    function automatic logic [TIME_W-1:0] later_time(input logic [TIME_W-1:0] t,
                                                     input int unsigned step);
        longint unsigned sum;
        sum = longint'(t) + step;
        return (sum > TIME_MAX) ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    // Offer one request, idling between bursts, and hold it until taken
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic [VERTEX_W-1:0] from_v,
                                input logic [VERTEX_W-1:0] to_v,
                                input logic [TIME_W-1:0] dep_t,
                                input logic [TIME_W-1:0] arr_t);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, arr_t, dep_t, to_v, from_v};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        case (op)
            OP_START: start_count++;
            OP_EDGE:  scan_count++;
            OP_READ:  read_count++;
            default:  other_count++;
        endcase
    endtask

    // Drop valid and wait for every outstanding result
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
        burst_left = 0;
    endtask

    // One query: a start, edges in departure order mostly from labelled
    // vertices, occasional reads in between and a few reads at the end
    task automatic run_query(input int unsigned edge_count);
        logic [VERTEX_W-1:0] touched[$];
        logic [VERTEX_W-1:0] from_v;
        logic [TIME_W-1:0]   now;
        logic [TIME_W-1:0]   dep_t;
        int unsigned         k;
        from_v = pick_vertex();
        now    = pick_start_time();
        touched.insert(touched.size(), from_v);
        send_request(OP_START, from_v, any_vertex(), now, any_time());
        for (k = 0; k < edge_count; k++) begin
            if ($urandom_range(0, 9) < 8)
                from_v = touched[$urandom_range(0, touched.size() - 1)];
            else
                from_v = pick_vertex();
            touched.insert(touched.size(), pick_vertex());
            dep_t = later_time(now, $urandom_range(0, 40));
            now   = dep_t;
            send_request(OP_EDGE, from_v, touched[touched.size() - 1], dep_t,
                         later_time(dep_t, $urandom_range(0, 120)));
            if ($urandom_range(0, 4) == 0)
                send_request(OP_READ, touched[$urandom_range(0, touched.size() - 1)],
                             any_vertex(), any_time(), any_time());
        end
        repeat ($urandom_range(1, 3))
            send_request(OP_READ, touched[$urandom_range(0, touched.size() - 1)],
                         any_vertex(), any_time(), any_time());
    endtask

    // Unstructured requests over the full field ranges
    task automatic send_noise();
        logic [OP_W-1:0] op;
        op = ($urandom_range(0, 19) == 0) ? OP_UNKNOWN
                                          : OP_W'($urandom_range(OP_START, OP_READ));
        send_request(op, ($urandom_range(0, 1) != 0) ? any_vertex() : pick_vertex(),
                     ($urandom_range(0, 1) != 0) ? any_vertex() : pick_vertex(),
                     any_time(), any_time());
    endtask

    initial begin
        int goal;
        int half;
        int roll;
        bit drained_mid;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_START;
        m_axis_tready = 1'b0;
        drained_mid   = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: nothing reached yet
        send_request(OP_READ, 16'd0, 16'd0, '0, '0);
        send_request(OP_EDGE, 16'd0, 16'd1, '0, '0);
        // Top vertex as source, departure zero still scanned
        send_request(OP_START, 16'hFFFF, 16'h0000, '0, TIME_MAX);
        send_request(OP_EDGE, 16'hFFFF, 16'h0000, '0, '0);
        send_request(OP_EDGE, 16'h0000, 16'hFFFF, '0, '0);
        send_request(OP_READ, 16'h0000, 16'hFFFF, TIME_MAX, TIME_MAX);
        // New query clears old flags; latest possible times
        send_request(OP_START, 16'h0000, 16'hFFFF, TIME_MAX, '0);
        send_request(OP_READ, 16'hFFFF, 16'h0000, '0, '0);
        send_request(OP_EDGE, 16'h0000, 16'h0001, TIME_MAX, TIME_MAX);
        send_request(OP_EDGE, 16'h0000, 16'h0002, TIME_MAX - 1, 31'd5);
        // Set, keep, lower, tie, chain and self loops
        send_request(OP_START, 16'd100, 16'd0, 31'd1000, 31'd0);
        send_request(OP_EDGE, 16'd100, 16'd200, 31'd1000, 31'd1500);
        send_request(OP_EDGE, 16'd100, 16'd200, 31'd1100, 31'd1600);
        send_request(OP_EDGE, 16'd100, 16'd200, 31'd1200, 31'd1400);
        send_request(OP_EDGE, 16'd100, 16'd200, 31'd1300, 31'd1400);
        send_request(OP_EDGE, 16'd200, 16'd300, 31'd1400, 31'd1450);
        send_request(OP_EDGE, 16'd300, 16'd300, 31'd1450, 31'd1450);
        send_request(OP_EDGE, 16'd100, 16'd100, 31'd1000, 31'd900);
        send_request(OP_EDGE, 16'd200, 16'd400, 31'd1399, 31'd1420);
        send_request(OP_UNKNOWN, 16'hFFFF, 16'hFFFF, TIME_MAX, TIME_MAX);
        send_request(OP_READ, 16'd300, 16'd0, '0, '0);
        send_request(OP_READ, 16'd400, 16'd0, '0, '0);
        send_request(OP_START, 16'hAAAA, 16'h5555, 31'h2AAA_AAAA, 31'h5555_5555);
        send_request(OP_EDGE, 16'hAAAA, 16'h5555, 31'h5555_5555, 31'h2AAA_AAAB);
        hold_until_drained();

        // Random: mostly well-formed queries, some noise; halfway, drain and then run
        // enough starts, each followed by a read, to roll the block's epoch tags
        goal = start_count + scan_count + read_count + other_count + RANDOM_ITEMS;
        half = goal - RANDOM_ITEMS / 2;
        while (start_count + scan_count + read_count + other_count < goal) begin
            if (!drained_mid && start_count + scan_count + read_count + other_count >= half)
            begin
                hold_until_drained();
                repeat (WRAP_STARTS) begin
                    send_request(OP_START, pick_vertex(), any_vertex(), pick_start_time(),
                                 any_time());
                    send_request(OP_READ, pick_vertex(), any_vertex(), any_time(),
                                 any_time());
                end
                drained_mid = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 15)
                repeat ($urandom_range(1, 4)) send_noise();
            else if (roll < 50)
                run_query($urandom_range(1, 3));
            else if (roll < 85)
                run_query($urandom_range(4, 12));
            else
                run_query($urandom_range(13, 40));
        end

        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d requests: %0d query starts, %0d edge scans, %0d label reads,",
                 start_count + scan_count + read_count + other_count, start_count,
                 scan_count, read_count);
        $display("%0d unknown operations, under bursty input and random result stalls.",
                 other_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
